// ===== hdl/mktd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mktd_pkg;

    // Store depth and register map
    localparam int unsigned MAX_SYMBOLS = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_LIMIT  = 2'd2;

    // Register reset values
    localparam logic [15:0] NOISE_LIMIT_RST = 16'd469;
    localparam logic [15:0] DOT_LIMIT_RST   = 16'd3125;
    localparam logic [15:0] DASH_LIMIT_RST  = 16'd9375;

    // Echo symbols
    localparam logic [6:0] CH_NONE  = 7'h00;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_DASH  = 7'h2D;
    localparam logic [6:0] CH_GAP   = 7'h5F;
    localparam logic [6:0] CH_QUERY = 7'h3F;

    // Letters by code length, index = symbols first to last, dash 1
    localparam logic [6:0] LETTERS1 [0:1] = '{7'h45, 7'h54};
    localparam logic [6:0] LETTERS2 [0:3] = '{7'h49, 7'h41, 7'h4E, 7'h4D};
    localparam logic [6:0] LETTERS3 [0:7] = '{7'h53, 7'h55, 7'h52, 7'h57,
                                              7'h44, 7'h4B, 7'h47, 7'h4F};
    localparam logic [6:0] LETTERS4 [0:15] = '{7'h48, 7'h56, 7'h46, 7'h00,
                                               7'h4C, 7'h00, 7'h50, 7'h4A,
                                               7'h42, 7'h58, 7'h43, 7'h59,
                                               7'h5A, 7'h51, 7'h00, 7'h00};

    // What one key edge leaves for the output side
    typedef struct packed {
        logic [6:0] ch0;
        logic       v0;
        logic [6:0] ch1;
        logic       two;
        logic       rising;
    } rec_t;

    // Walk the code into a letter; zero means no letter for that code
    function automatic logic [6:0] decode_letter(input logic [2:0] count,
                                                 input logic [MAX_SYMBOLS-1:0] dash);
        logic [6:0] res;
        case (count)
            3'd0: res = CH_QUERY;
            3'd1: res = LETTERS1[dash[0]];
            3'd2: res = LETTERS2[{dash[0], dash[1]}];
            3'd3: res = LETTERS3[{dash[0], dash[1], dash[2]}];
            default: res = LETTERS4[{dash[0], dash[1], dash[2], dash[3]}];
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/mktd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mktd_front
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [15:0]                     capture_time,
    input  wire logic                            key_level,
    input  wire logic                            cfg_we,
    input  wire logic [mktd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [15:0]                     cfg_data,
    input  wire logic                            q_full,
    output logic                                 q_wr,
    output mktd_pkg::rec_t                       q_rec
);

    logic [15:0] noise_limit_reg;
    logic [15:0] dot_limit_reg;
    logic [15:0] dash_limit_reg;
    logic [15:0] prev_stamp_reg;
    logic        rising_reg;
    logic        rising_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [mktd_pkg::MAX_SYMBOLS-1:0] dash_reg;
    logic [mktd_pkg::MAX_SYMBOLS-1:0] dash_next;

    logic [15:0] interval;
    logic        over_dash;
    logic        gap;
    logic        is_dot;
    logic        is_dash;
    logic        store_full;
    logic [6:0]  letter;
    logic        accept;

    // Hold off the sender while the queue is full
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_wr     = accept;

    // Classify the interval since the previous edge
    assign interval   = capture_time - prev_stamp_reg;
    assign over_dash  = interval > dash_limit_reg;
    assign gap        = over_dash && (count_reg != 3'd0);
    assign is_dot     = (interval > noise_limit_reg) && (interval <= dot_limit_reg);
    assign is_dash    = (interval > dot_limit_reg) && (interval <= dash_limit_reg);
    assign store_full = count_reg >= 3'(mktd_pkg::MAX_SYMBOLS);
    assign letter     = mktd_pkg::decode_letter(count_reg, dash_reg);

    // Build the record and the next symbol store
    always_comb
    begin
        q_rec      = '0;
        count_next = count_reg;
        dash_next  = dash_reg;
        rising_next = rising_reg;
        if (gap || !key_level)
        begin
            if (over_dash || store_full)
            begin
                q_rec.ch0  = mktd_pkg::CH_GAP;
                q_rec.v0   = 1'b1;
                q_rec.ch1  = letter;
                q_rec.two  = letter != mktd_pkg::CH_NONE;
                count_next = 3'd0;
                dash_next  = '0;
            end
            else if (is_dot)
            begin
                q_rec.ch0  = mktd_pkg::CH_DOT;
                q_rec.v0   = 1'b1;
                dash_next[count_reg[1:0]] = 1'b0;
                count_next = count_reg + 3'd1;
            end
            else if (is_dash)
            begin
                q_rec.ch0  = mktd_pkg::CH_DASH;
                q_rec.v0   = 1'b1;
                dash_next[count_reg[1:0]] = 1'b1;
                count_next = count_reg + 3'd1;
            end
            if (!gap)
            begin
                rising_next = 1'b1;
            end
        end
        else
        begin
            rising_next = 1'b0;
        end
        q_rec.rising = rising_next;
    end

    // Advance the decoder state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_stamp_reg <= 16'd0;
            rising_reg     <= 1'b1;
            count_reg      <= 3'd0;
            dash_reg       <= '0;
        end
        else if (accept)
        begin
            prev_stamp_reg <= capture_time;
            rising_reg     <= rising_next;
            count_reg      <= count_next;
            dash_reg       <= dash_next;
        end
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_limit_reg <= mktd_pkg::NOISE_LIMIT_RST;
            dot_limit_reg   <= mktd_pkg::DOT_LIMIT_RST;
            dash_limit_reg  <= mktd_pkg::DASH_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mktd_pkg::REG_NOISE_LIMIT: noise_limit_reg <= cfg_data;
                mktd_pkg::REG_DOT_LIMIT:   dot_limit_reg   <= cfg_data;
                mktd_pkg::REG_DASH_LIMIT:  dash_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mktd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mktd_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire mktd_pkg::rec_t wr_rec,
    output logic                full,
    input  wire logic           rd,
    output mktd_pkg::rec_t      rd_rec,
    output logic                empty
);

    mktd_pkg::rec_t slot_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full   = fill_reg == 2'd2;
    assign empty  = fill_reg == 2'd0;
    assign rd_rec = slot_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        fill_next = fill_reg;
        if (wr && !rd)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Store the incoming record
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mktd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mktd_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire mktd_pkg::rec_t q_rec,
    output logic                q_rd,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [6:0]          character,
    output logic                char_valid,
    output logic                next_edge_rising,
    output logic                last
);

    logic       out_valid_reg;
    logic       pend_reg;
    logic [6:0] pend_ch_reg;
    logic [6:0] character_reg;
    logic       char_valid_reg;
    logic       rising_reg;
    logic       last_reg;
    logic       load_ok;

    // Output register frees when empty or being taken
    assign load_ok = !out_valid_reg || !out_stall;
    assign q_rd    = load_ok && !pend_reg && !q_empty;

    assign out_valid        = out_valid_reg;
    assign character        = character_reg;
    assign char_valid       = char_valid_reg;
    assign next_edge_rising = rising_reg;
    assign last             = last_reg;

    // Control: output valid and second-result pending
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (load_ok)
        begin
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= q_rec.two;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: first result from the queue, then the held letter
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            if (pend_reg)
            begin
                character_reg  <= pend_ch_reg;
                char_valid_reg <= 1'b1;
                last_reg       <= 1'b1;
            end
            else if (!q_empty)
            begin
                character_reg  <= q_rec.ch0;
                char_valid_reg <= q_rec.v0;
                last_reg       <= !q_rec.two;
                rising_reg     <= q_rec.rising;
                pend_ch_reg    <= q_rec.ch1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/morse_key_timing_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Morse key timing decoder.
// Input channel (in_valid / in_stall): one key edge per item, the 16-bit
// timer stamp capture_time and key_level (1 pressed, 0 released).
// Output channel (out_valid / out_stall): one or two results per key edge,
// each carrying character, char_valid, next_edge_rising and last; last marks
// the final result of an edge. An edge with nothing to echo gives a single
// result with char_valid low.
// Configuration: cfg_we writes cfg_data into noise, dot or dash limit
// selected by cfg_index; other indexes are ignored. Write only while idle.
// Flow: an accepted item is written into the queue and then loaded into the
// output register, which presents its first result. While out_stall is low
// the output register sends one result per cycle; a gap mark and a letter go out in turn.
// A two-entry queue sits between the classifier and the output register, so
// the input keeps taking items while a result waits on a stalled receiver;
// in_stall rises only when that queue is full.
// Reset: limits return to 469 / 3125 / 9375, the stamp to zero, the symbol
// store empties and the next edge to capture is rising.
module morse_key_timing_decoder_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [15:0]                     capture_time,
    input  wire logic                            key_level,
    input  wire logic                            cfg_we,
    input  wire logic [mktd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [15:0]                     cfg_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [6:0]                           character,
    output logic                                 char_valid,
    output logic                                 next_edge_rising,
    output logic                                 last
);

    logic           q_wr;
    logic           q_rd;
    logic           q_full;
    logic           q_empty;
    mktd_pkg::rec_t wr_rec;
    mktd_pkg::rec_t rd_rec;

    mktd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .capture_time (capture_time),
        .key_level    (key_level),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_wr         (q_wr),
        .q_rec        (wr_rec)
    );

    mktd_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_rec (wr_rec),
        .full   (q_full),
        .rd     (q_rd),
        .rd_rec (rd_rec),
        .empty  (q_empty)
    );

    mktd_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_rec            (rd_rec),
        .q_rd             (q_rd),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .character        (character),
        .char_valid       (char_valid),
        .next_edge_rising (next_edge_rising),
        .last             (last)
    );

endmodule
`default_nettype wire

// ===== tb/tb_morse_key_timing_decoder_top.sv =====
`timescale 1ns / 1ps
module tb_morse_key_timing_decoder_top;

    // Symbol store codes
    localparam logic [1:0] SYM_EMPTY = 2'd0;
    localparam logic [1:0] SYM_DOT   = 2'd1;
    localparam logic [1:0] SYM_DASH  = 2'd2;

    localparam int DIRECTED_ROWS  = 27;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int NUM_PHASES     = 8;

    typedef enum logic [1:0] {SPAN_NOISE, SPAN_DOT, SPAN_DASH, SPAN_GAP} span_kind_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       cv;
        logic       rising;
        logic       fin;
    } echo_t;

    typedef struct packed {
        logic [15:0] stamp;
        logic        pressed;
        logic        typed;
        logic [1:0]  n_echo;
        logic [6:0]  echo0;
        logic [6:0]  echo1;
    } edge_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] capture_time;
    logic        key_level;
    logic        cfg_we;
    logic [mktd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  character;
    logic        char_valid;
    logic        next_edge_rising;
    logic        last;

    // Decoder state as the block should hold it
    logic [15:0] lim_noise = mktd_pkg::NOISE_LIMIT_RST;
    logic [15:0] lim_dot   = mktd_pkg::DOT_LIMIT_RST;
    logic [15:0] lim_dash  = mktd_pkg::DASH_LIMIT_RST;
    logic [15:0] last_stamp = 16'd0;
    logic        want_rising = 1'b1;
    logic [1:0]  sym_store [4] = '{SYM_EMPTY, SYM_EMPTY, SYM_EMPTY, SYM_EMPTY};
    logic [2:0]  sym_count = 3'd0;
    logic [6:0]  echo_buf [2];
    int          echo_n;

    echo_t       echo_queue [$];
    int          mismatches = 0;
    int          edges_sent = 0;
    logic [15:0] key_clock = 16'd0;
    logic        calm = 1'b0;
    logic        rx_hold_req = 1'b0;

    edge_row_t   directed_rows [DIRECTED_ROWS];

    morse_key_timing_decoder_top DUT
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .capture_time     (capture_time),
        .key_level        (key_level),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .character        (character),
        .char_valid       (char_valid),
        .next_edge_rising (next_edge_rising),
        .last             (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch in %0s: got %0h, want %0h at %0t", what, got, want, $time);
    endtask

    // Walk the Morse tree: heap order, dot left, dash right
    function automatic logic [6:0] letter_of(input logic [2:0] n, input logic [3:0] code);
        string tree;
        int    pos;
        logic [7:0] c;
        tree = "ETIANMSURWDKGOHVF*L*PJBXCYZQ**";
        if (n == 0)
            return mktd_pkg::CH_QUERY;
        pos = (1 << n) - 2 + code;
        c = tree[pos];
        return (c == "*") ? mktd_pkg::CH_NONE : c[6:0];
    endfunction

    task automatic push_echo(input logic [6:0] c);
        if (echo_n < 2)
        begin
            echo_buf[echo_n] = c;
            echo_n++;
        end
    endtask

    // Class one interval: letter gap (or full store), dot, dash, else drop it
    task automatic classify_span(input logic [15:0] span);
        logic [3:0] code;
        logic [6:0] letter;
        if (span > lim_dash || sym_count >= mktd_pkg::MAX_SYMBOLS)
        begin
            push_echo(mktd_pkg::CH_GAP);
            code = 4'd0;
            for (int i = 0; i < sym_count; i++)
                code = {code[2:0], sym_store[i] == SYM_DASH};
            letter = letter_of(sym_count, code);
            if (letter != mktd_pkg::CH_NONE)
                push_echo(letter);
            for (int i = 0; i < 4; i++)
                sym_store[i] = SYM_EMPTY;
            sym_count = 3'd0;
        end
        else if (span > lim_noise && span <= lim_dot)
        begin
            push_echo(mktd_pkg::CH_DOT);
            sym_store[sym_count[1:0]] = SYM_DOT;
            sym_count++;
        end
        else if (span > lim_dot && span <= lim_dash)
        begin
            push_echo(mktd_pkg::CH_DASH);
            sym_store[sym_count[1:0]] = SYM_DASH;
            sym_count++;
        end
    endtask

    // Advance the decoder by one key edge and queue what it should echo
    task automatic decode_key_edge(input logic [15:0] stamp, input logic pressed);
        logic [15:0] span;
        span = stamp - last_stamp;
        echo_n = 0;
        if (span > lim_dash && sym_count != 0)
            classify_span(span);
        else if (pressed)
            want_rising = 1'b0;
        else
        begin
            classify_span(span);
            want_rising = 1'b1;
        end
        last_stamp = stamp;
        if (echo_n == 0)
            echo_queue.push_back('{mktd_pkg::CH_NONE, 1'b0, want_rising, 1'b1});
        for (int k = 0; k < echo_n; k++)
            echo_queue.push_back('{echo_buf[k], 1'b1, want_rising, k == echo_n - 1});
    endtask

    function automatic logic [15:0] pick_span(input span_kind_t kind);
        int lo;
        int hi;
        case (kind)
            SPAN_NOISE:
            begin
                lo = 0;
                hi = int'(lim_noise);
            end
            SPAN_DOT:
            begin
                lo = int'(lim_noise) + 1;
                hi = int'(lim_dot);
            end
            SPAN_DASH:
            begin
                lo = int'(lim_dot) + 1;
                hi = int'(lim_dash);
            end
            default:
            begin
                lo = int'(lim_dash) + 1;
                hi = 65535;
            end
        endcase
        if (lo > hi)
            return 16'($urandom_range(65535, 0));
        return 16'($urandom_range(hi, lo));
    endfunction

    // Offer one item and hold it until taken
    task automatic send_edge(input logic [15:0] stamp, input logic pressed);
        @(negedge clk);
        in_valid     <= 1'b1;
        capture_time <= stamp;
        key_level    <= pressed;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_key_edge(stamp, pressed);
        edges_sent++;
    endtask

    // Idle the sender for a random while, mostly not at all
    task automatic idle_sender();
        int gap;
        int r;
        r = $urandom_range(99, 0);
        if (calm || r < 55)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(3, 1);
        else
            gap = $urandom_range(40, 8);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic key_edge(input span_kind_t kind, input logic pressed);
        key_clock = key_clock + pick_span(kind);
        send_edge(key_clock, pressed);
        idle_sender();
    endtask

    // One keyed letter: press/release pairs, now and then a bounce, then a gap
    task automatic play_letter();
        int n_sym;
        n_sym = $urandom_range(5, 1);
        for (int i = 0; i < n_sym; i++)
        begin
            key_edge($urandom_range(1, 0) ? SPAN_DOT : SPAN_NOISE, 1'b1);
            if ($urandom_range(9, 0) == 0)
            begin
                key_edge(SPAN_NOISE, 1'b0);
                key_edge(SPAN_NOISE, 1'b1);
            end
            key_edge($urandom_range(1, 0) ? SPAN_DASH : SPAN_DOT, 1'b0);
        end
        key_edge(SPAN_GAP, $urandom_range(3, 0) != 0);
    endtask

    // Drop valid and wait for every queued echo to drain
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (echo_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [mktd_pkg::CFG_IDX_W-1:0] idx,
                               input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            mktd_pkg::REG_NOISE_LIMIT: lim_noise = val;
            mktd_pkg::REG_DOT_LIMIT:   lim_dot   = val;
            mktd_pkg::REG_DASH_LIMIT:  lim_dash  = val;
            default: ;
        endcase
    endtask

    // Check each echo against the oldest expectation
    always @(posedge clk)
    begin : echo_check
        echo_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (echo_queue.size() == 0)
                flag_mismatch("result with nothing expected", {9'd0, character}, 16'd0);
            else
            begin
                want = echo_queue.pop_front();
                if (character !== want.ch)
                    flag_mismatch("character", {9'd0, character}, {9'd0, want.ch});
                if (char_valid !== want.cv)
                    flag_mismatch("char_valid", {15'd0, char_valid}, {15'd0, want.cv});
                if (next_edge_rising !== want.rising)
                    flag_mismatch("next_edge_rising", {15'd0, next_edge_rising},
                                  {15'd0, want.rising});
                if (last !== want.fin)
                    flag_mismatch("last", {15'd0, last}, {15'd0, want.fin});
            end
        end
    end

    // Receiver: random stalls, a long hold-off on request, none while calm
    initial
    begin
        int run;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
            end
            else if (calm)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= ($urandom_range(3, 0) == 0);
                run = ($urandom_range(19, 0) == 0) ? $urandom_range(50, 15)
                                                    : $urandom_range(2, 0);
                repeat (run) @(negedge clk);
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [15:0] nl;
        logic [15:0] dl;
        logic [15:0] gl;
        int          quota;
        int          phase_end;
        int          phase_start;
        logic        hold_done;
        edge_row_t   row;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        capture_time = 16'd0;
        key_level    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = mktd_pkg::REG_NOISE_LIMIT;
        cfg_data     = 16'd0;
        hold_done    = 1'b0;

        // Directed edges at reset limits 469 / 3125 / 9375
        directed_rows = '{
            '{16'd100,   1'b1, 1'b1, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd1100,  1'b0, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd2000,  1'b1, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd7000,  1'b0, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd20000, 1'b1, 1'b1, 2'd2, mktd_pkg::CH_GAP,  7'h41},
            '{16'd20469, 1'b0, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd20469, 1'b1, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd20939, 1'b0, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd21000, 1'b1, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd24125, 1'b0, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd24200, 1'b1, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd27326, 1'b0, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd27400, 1'b1, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd36775, 1'b0, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd36800, 1'b1, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd37300, 1'b0, 1'b1, 2'd1, mktd_pkg::CH_GAP,  mktd_pkg::CH_NONE},
            '{16'd46676, 1'b0, 1'b1, 2'd2, mktd_pkg::CH_GAP,  mktd_pkg::CH_QUERY},
            '{16'd65535, 1'b1, 1'b1, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd535,   1'b0, 1'b1, 2'd1, mktd_pkg::CH_DOT,  mktd_pkg::CH_NONE},
            '{16'd600,   1'b1, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd1100,  1'b0, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd1200,  1'b1, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd1700,  1'b0, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd1800,  1'b1, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd2300,  1'b0, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd2400,  1'b1, 1'b0, 2'd0, mktd_pkg::CH_NONE, mktd_pkg::CH_NONE},
            '{16'd7400,  1'b0, 1'b1, 2'd2, mktd_pkg::CH_GAP,  7'h48}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table; typed rows also check the prediction itself
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            key_clock = row.stamp;
            send_edge(row.stamp, row.pressed);
            if (row.typed)
            begin
                if (echo_n != row.n_echo)
                    flag_mismatch("directed echo count", 16'(echo_n), {14'd0, row.n_echo});
                else if (echo_n > 0 && echo_buf[0] != row.echo0)
                    flag_mismatch("directed first echo", {9'd0, echo_buf[0]},
                                  {9'd0, row.echo0});
                else if (echo_n > 1 && echo_buf[1] != row.echo1)
                    flag_mismatch("directed second echo", {9'd0, echo_buf[1]},
                                  {9'd0, row.echo1});
            end
            idle_sender();
        end

        // Random phases, each under its own limits
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    nl = mktd_pkg::NOISE_LIMIT_RST;
                    dl = mktd_pkg::DOT_LIMIT_RST;
                    gl = mktd_pkg::DASH_LIMIT_RST;
                    quota = 520;
                end
                1: begin nl = 16'd0;     dl = 16'hFFFF; gl = 16'hFFFF; quota = 150; end
                2: begin nl = 16'hFFFF;  dl = 16'hFFFF; gl = 16'hFFFF; quota = 100; end
                3: begin nl = 16'd0;     dl = 16'd0;    gl = 16'd0;    quota = 120; end
                4: begin nl = 16'd5000;  dl = 16'd1000; gl = 16'd3000; quota = 150; end
                5: begin nl = 16'd20;    dl = 16'd200;  gl = 16'd600;  quota = 250; end
                default:
                begin
                    nl = 16'($urandom_range(4000, 0));
                    dl = nl + 16'($urandom_range(8000, 0));
                    gl = dl + 16'($urandom_range(20000, 0));
                    quota = 170;
                end
            endcase
            settle();
            write_limit(mktd_pkg::REG_NOISE_LIMIT, nl);
            write_limit(mktd_pkg::REG_DOT_LIMIT, dl);
            write_limit(mktd_pkg::REG_DASH_LIMIT, gl);
            calm = (ph == 2);
            phase_start = edges_sent;
            phase_end = edges_sent + quota;
            while (edges_sent < phase_end)
            begin
                // Hold the receiver off once so the block backs up
                if (ph == 0 && !hold_done && edges_sent >= phase_start + 100)
                begin
                    rx_hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                if ($urandom_range(3, 0) != 0)
                    play_letter();
                else
                begin
                    repeat ($urandom_range(3, 1))
                    begin
                        key_clock = 16'($urandom_range(65535, 0));
                        send_edge(key_clock, 1'($urandom_range(1, 0)));
                        idle_sender();
                    end
                end
            end
            calm = 1'b0;
        end

        settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mktd_pkg.sv
hdl/mktd_front.sv
hdl/mktd_queue.sv
hdl/mktd_back.sv
hdl/morse_key_timing_decoder_top.sv
tb/tb_morse_key_timing_decoder_top.sv
